/* src/coap_option_stream_encoder_assert.svh */
// Assertion macros shared by the CoAP option encoder modules.
`ifndef COAP_OPTION_STREAM_ENCODER_ASSERT_SVH
`define COAP_OPTION_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define COAP_ENC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define COAP_ENC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/coap_enc_pkg.sv */
// Types and constants of the CoAP option stream encoder.
`timescale 1ns / 1ps
`default_nettype none
package coap_enc_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN  = 2'd0,
    ACT_HEADER = 2'd1,
    ACT_VALUE  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VT_EMPTY  = 2'd0,
    VT_OPAQUE = 2'd1,
    VT_UINT   = 2'd2,
    VT_STRING = 2'd3
  } vtype_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ORDER   = 2'd1,
    ERR_BYTE    = 2'd2,
    ERR_PENDING = 2'd3
  } err_t;

  localparam int unsigned MAX_BYTES = 7;      // header + 2 delta ext + 4 uint bytes
  localparam logic [3:0]  NIB_EXT1  = 4'd13;  // one extension byte follows
  localparam logic [3:0]  NIB_EXT2  = 4'd14;  // two extension bytes follow
  localparam logic [15:0] EXT1_BASE = 16'd13;
  localparam logic [15:0] EXT2_BASE = 16'd269;
  localparam logic [7:0]  LEN_BASE  = 8'd13;
  localparam logic [7:0]  UINT_LEN  = 8'd4;

  // One queued job: the bytes to send, index of the final byte, error code.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                lst;
    err_t                      err;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* src/coap_enc_front.sv */
// Front end: accepts items, tracks option state and builds byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module coap_enc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,
  input  wire logic [3:0]           in_tuser,
  input  wire coap_enc_pkg::q_stat_t q_stat,
  output logic                      push,
  output coap_enc_pkg::job_t        push_job
);

  logic [15:0] prev_r, prev_nxt;
  logic [7:0]  rem_r, rem_nxt;

  logic                  accept;
  coap_enc_pkg::action_t act;
  coap_enc_pkg::vtype_t  vtype;
  logic [15:0]           num;
  logic [7:0]            vlen;
  logic [31:0]           uval;
  logic [7:0]            dbyte;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign act       = coap_enc_pkg::action_t'(in_tuser[1:0]);
  assign vtype     = coap_enc_pkg::vtype_t'(in_tuser[3:2]);
  assign num       = in_tdata[15:0];
  assign vlen      = in_tdata[23:16];
  assign uval      = in_tdata[55:24];
  assign dbyte     = in_tdata[63:56];

  always_comb begin
    logic [15:0] delta;
    logic [15:0] ext1;
    logic [15:0] ext2;
    logic [7:0]  len;
    logic [3:0]  dnib;
    logic [3:0]  lnib;
    logic [2:0]  pos;
    logic        has_res;

    delta    = num - prev_r;
    ext1     = delta - coap_enc_pkg::EXT1_BASE;
    ext2     = delta - coap_enc_pkg::EXT2_BASE;
    push_job = '0;
    prev_nxt = prev_r;
    rem_nxt  = rem_r;
    has_res  = 1'b0;
    pos      = 3'd0;

    unique case (vtype)
      coap_enc_pkg::VT_EMPTY: len = 8'd0;
      coap_enc_pkg::VT_UINT:  len = coap_enc_pkg::UINT_LEN;
      default:                len = vlen;
    endcase

    if (delta < coap_enc_pkg::EXT1_BASE) begin
      dnib = delta[3:0];
    end else if (delta < coap_enc_pkg::EXT2_BASE) begin
      dnib = coap_enc_pkg::NIB_EXT1;
    end else begin
      dnib = coap_enc_pkg::NIB_EXT2;
    end
    lnib = (len < coap_enc_pkg::LEN_BASE) ? len[3:0] : coap_enc_pkg::NIB_EXT1;

    unique case (act)
      coap_enc_pkg::ACT_BEGIN: begin
        prev_nxt = '0;
        rem_nxt  = '0;
      end
      coap_enc_pkg::ACT_VALUE: begin
        has_res = 1'b1;
        if (rem_r == 8'd0) begin
          push_job.err = coap_enc_pkg::ERR_BYTE;
        end else begin
          push_job.bytes[0] = dbyte;
          rem_nxt           = rem_r - 8'd1;
        end
      end
      coap_enc_pkg::ACT_HEADER: begin
        has_res = 1'b1;
        if (rem_r != 8'd0) begin
          push_job.err = coap_enc_pkg::ERR_PENDING;
        end else if (num < prev_r) begin
          push_job.err = coap_enc_pkg::ERR_ORDER;
        end else begin
          push_job.bytes[0] = {dnib, lnib};
          pos               = 3'd1;
          if (dnib == coap_enc_pkg::NIB_EXT1) begin
            push_job.bytes[pos] = ext1[7:0];
            pos                 = pos + 3'd1;
          end else if (dnib == coap_enc_pkg::NIB_EXT2) begin
            push_job.bytes[pos] = ext2[15:8];
            pos                 = pos + 3'd1;
            push_job.bytes[pos] = ext2[7:0];
            pos                 = pos + 3'd1;
          end
          if (lnib == coap_enc_pkg::NIB_EXT1) begin
            push_job.bytes[pos] = len - coap_enc_pkg::LEN_BASE;
            pos                 = pos + 3'd1;
          end
          if (vtype == coap_enc_pkg::VT_UINT) begin
            push_job.bytes[pos] = uval[31:24];
            pos                 = pos + 3'd1;
            push_job.bytes[pos] = uval[23:16];
            pos                 = pos + 3'd1;
            push_job.bytes[pos] = uval[15:8];
            pos                 = pos + 3'd1;
            push_job.bytes[pos] = uval[7:0];
            pos                 = pos + 3'd1;
          end
          push_job.lst = pos - 3'd1;
          prev_nxt     = num;
          rem_nxt      = (vtype == coap_enc_pkg::VT_OPAQUE ||
                          vtype == coap_enc_pkg::VT_STRING) ? len : 8'd0;
        end
      end
      default: begin
        has_res = 1'b0;   // unused action code: dropped
      end
    endcase

    push = accept && has_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      rem_r  <= '0;
    end else if (accept) begin
      prev_r <= prev_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/coap_enc_queue.sv */
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "coap_option_stream_encoder_assert.svh"
module coap_enc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire coap_enc_pkg::job_t push_job,
  input  wire logic               pop,
  output coap_enc_pkg::job_t      head,
  output coap_enc_pkg::q_stat_t   stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  coap_enc_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `COAP_ENC_ASSERT_IMP(a_no_push_full, push, !stat.full, "job pushed into full queue")
  `COAP_ENC_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count lost a job")

endmodule
`default_nettype wire

/* src/coap_enc_back.sv */
// Byte sequencer: walks the head job one output item per cycle while a job is queued and out_tready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "coap_option_stream_encoder_assert.svh"
module coap_enc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire coap_enc_pkg::job_t    head,
  input  wire coap_enc_pkg::q_stat_t q_stat,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  output logic [1:0]                 out_tuser
);

  logic [2:0] idx_r, idx_nxt;
  logic       fire;

  assign out_tvalid = !q_stat.empty;
  assign out_tdata  = head.bytes[idx_r];
  assign out_tlast  = (idx_r == head.lst);
  assign out_tuser  = head.err;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_tlast ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `COAP_ENC_ASSERT_IMP(a_idx_range, !q_stat.empty, idx_r <= head.lst, "byte index past job end")
  `COAP_ENC_ASSERT_NXT(a_idx_restart, pop, idx_r == 3'd0, "index not rewound after job")

endmodule
`default_nettype wire

/* src/coap_option_stream_encoder.sv */
// CoAP option stream encoder: top level joining front end, job queue and sequencer.
// An accepted item's job is registered in the job queue; its bytes go out once it is the queue head.
// Throughput: one input item per cycle while each job yields one byte and out_tready
//   is high; a header job holds 1 to 7 bytes, sent one output byte per cycle likewise.
// The job queue (QUEUE_DEPTH entries) lets the input side run on during bursts.
// Reset: rst_n synchronous, active low; clears previous number, pending count, queue.
`timescale 1ns / 1ps
`default_nettype none
module coap_option_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // opt_num[15:0], value_length[23:16],
                                       // uint_word[55:24], data_byte[63:56]
  input  wire logic [3:0]  in_tuser,   // action[1:0], value_type[3:2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tlast,  // last
  output logic [1:0]       out_tuser   // error[1:0]
);

  // Front end classifies each item; begin items only reset state, unused items are dropped.
  // Every item that yields output becomes one job of up to seven bytes.
  logic                  push;
  logic                  pop;
  coap_enc_pkg::job_t    push_job;
  coap_enc_pkg::job_t    head;
  coap_enc_pkg::q_stat_t q_stat;

  coap_enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // Jobs wait here; input ready depends only on queue fill, never on out_tready.
  coap_enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Sequencer sends the head job byte by byte, tlast on its final byte.
  coap_enc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
